// ===== design/drf_pkg.sv =====
// ----------------------------------------------------------------------------
// drf_pkg: shared definitions for the deduplicating ring FIFO
// Sizes, command and status codes, and the structs that pass between the
// controller, the datapath and the ports.
// ----------------------------------------------------------------------------
package drf_pkg;

    localparam int DEPTH  = 1024;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 11;

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_UPUSH = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;
    localparam logic [1:0] CMD_PEEK  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    typedef logic [WIDTH-1:0]  t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] data_in;
    } t_drf_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data_out;
        logic [OCC_W-1:0]  occupancy;
    } t_drf_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // capture the accepted command
        logic       write;      // store the word at the tail
        logic       pop;        // advance the head
        logic       scan_start; // arm the duplicate scan at the head
        logic       scan_step;  // read address comes from the scan pointer
        logic       finish;     // load the result register
        logic       head_data;  // result carries the head word
        logic [1:0] res_status;
    } t_drf_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       full;
        logic       match;
        logic       scan_done;
    } t_drf_stat;

endpackage

// ===== design/drf_ctrl.sv =====
// ----------------------------------------------------------------------------
// drf_ctrl: command sequencer of the deduplicating ring FIFO
// Decodes each accepted command, walks the duplicate scan and tells the
// datapath when to store, pop and post a result.
// ----------------------------------------------------------------------------
module drf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  drf_pkg::t_drf_stat i_stat,
    output drf_pkg::t_drf_ctrl o_ctrl
);
    import drf_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_HEAD   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_PUSH, CMD_UPUSH: begin
                        if (i_stat.cmd == CMD_UPUSH && !i_stat.empty) begin
                            o_ctrl.scan_start = 1'b1;
                            n_state           = S_SCAN;
                        end else if (i_stat.full) begin
                            o_ctrl.finish     = 1'b1;
                            o_ctrl.res_status = ST_FULL;
                            n_state           = S_IDLE;
                        end else begin
                            o_ctrl.write      = 1'b1;
                            o_ctrl.finish     = 1'b1;
                            o_ctrl.res_status = ST_OK;
                            n_state           = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_stat.empty) begin
                            o_ctrl.finish     = 1'b1;
                            o_ctrl.res_status = ST_EMPTY;
                            n_state           = S_IDLE;
                        end else begin
                            // The head read is issued now and lands next cycle.
                            n_state = S_HEAD;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.match) begin
                    o_ctrl.finish     = 1'b1;
                    o_ctrl.res_status = ST_DUP;
                    n_state           = S_IDLE;
                end else if (i_stat.scan_done) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                    if (i_stat.full) begin
                        o_ctrl.res_status = ST_FULL;
                    end else begin
                        o_ctrl.write      = 1'b1;
                        o_ctrl.res_status = ST_OK;
                    end
                end
            end
            S_HEAD: begin
                o_ctrl.finish     = 1'b1;
                o_ctrl.head_data  = 1'b1;
                o_ctrl.res_status = ST_OK;
                o_ctrl.pop        = (i_stat.cmd == CMD_POP);
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/drf_datapath.sv =====
// ----------------------------------------------------------------------------
// drf_datapath: storage and pointers of the deduplicating ring FIFO
// Holds the slot memory, head, tail and count, the scan pointer with its
// registered compare, and the result register.
// ----------------------------------------------------------------------------
module drf_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drf_pkg::t_drf_in   i_item,
    input  drf_pkg::t_drf_ctrl i_ctrl,
    output drf_pkg::t_drf_stat o_stat,
    output logic               o_done,
    output drf_pkg::t_drf_out  o_result
);
    import drf_pkg::*;

    t_word mem [DEPTH];

    logic [1:0] r_cmd;
    t_word      r_word;
    t_addr      r_head;
    t_addr      r_tail;
    t_count     r_count;
    t_addr      r_scan_idx;
    t_count     r_scan_left;
    logic       r_cmp_valid;
    t_word      r_rd_data;
    logic       r_done;
    t_drf_out   r_result;

    t_addr      n_head;
    t_addr      n_tail;
    t_count     n_count;
    t_addr      rd_addr;
    logic       issue;

    function automatic t_addr wrap_inc(input t_addr idx);
        return (idx == LAST_IDX) ? '0 : idx + t_addr'(1);
    endfunction

    assign rd_addr = i_ctrl.scan_step ? r_scan_idx : r_head;
    assign issue   = i_ctrl.scan_step && (r_scan_left != '0);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.write) begin
            n_tail  = wrap_inc(r_tail);
            n_count = r_count + t_count'(1);
        end
        if (i_ctrl.pop) begin
            n_head  = wrap_inc(r_head);
            n_count = r_count - t_count'(1);
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == FULL_CNT);
    assign o_stat.match     = r_cmp_valid && (r_rd_data == r_word);
    assign o_stat.scan_done = !r_cmp_valid && (r_scan_left == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            mem[r_tail] <= r_word;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_item.cmd;
            r_word <= WIDTH'(i_item.data_in);
        end
        if (i_ctrl.scan_start) begin
            r_scan_idx  <= r_head;
            r_scan_left <= r_count;
        end else if (issue) begin
            r_scan_idx  <= wrap_inc(r_scan_idx);
            r_scan_left <= r_scan_left - t_count'(1);
        end
        if (i_ctrl.finish) begin
            r_result.status    <= i_ctrl.res_status;
            r_result.data_out  <= i_ctrl.head_data ? DATA_W'(r_rd_data) : '0;
            r_result.occupancy <= OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            // A compare is pending in the cycle after each scan read.
            r_cmp_valid <= issue;
            r_done      <= i_ctrl.finish;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== design/dedup_ring_fifo_core.sv =====
// ----------------------------------------------------------------------------
// dedup_ring_fifo_core: ring FIFO with push, unique push, pop and peek
// Fixed-capacity circular queue whose unique push skips words already stored.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on o_result with o_done, which is high for a single cycle, and
// the receiver cannot stall it. A push, or any command that finds the queue
// empty, is settled in the decode state; a successful pop or peek also
// passes the head state, since the head word comes from a memory with a
// registered read. A unique push reads the stored entries one per cycle
// through the single memory read port, from head to tail, and stops at the
// first match. A push into a full queue is dropped and reported full; a
// duplicate is reported ahead of full.
// ----------------------------------------------------------------------------
module dedup_ring_fifo_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  drf_pkg::t_drf_in  i_item,
    output logic              o_done,
    output drf_pkg::t_drf_out o_result
);
    import drf_pkg::*;

    t_drf_ctrl ctrl;
    t_drf_stat stat;

    drf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    drf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctrl   (ctrl),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== design/drf_checker.sv =====
// ----------------------------------------------------------------------------
// drf_checker: port-level checks for the deduplicating ring FIFO
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
module drf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input drf_pkg::t_drf_out o_result
);
    import drf_pkg::*;

    // Every command passes through decode after it is taken, so results never
    // come back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a command transfer");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (o_result.occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (o_result.occupancy == OCC_W'(DEPTH)))
        else $error("full status without a full queue");

    a_no_data_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.data_out == '0))
        else $error("data returned with a failing status");

endmodule

bind dedup_ring_fifo_core drf_checker u_drf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
